/* sv/fft_pkg.sv */
// ----------------------------------------------------------------------------
// FFT package
// Constants, types and the twiddle table for the in-place radix-2 FFT.
// ----------------------------------------------------------------------------
package fft_pkg;

  localparam int unsigned Points  = 1024;
  localparam int unsigned AddrW   = $clog2(Points);
  localparam int unsigned Passes  = AddrW;
  localparam int unsigned PassW   = $clog2(Passes + 1);
  localparam int unsigned TwBits  = 16;
  localparam int unsigned Quarter = Points / 4;
  localparam int unsigned QAddrW  = $clog2(Quarter + 1);
  localparam int unsigned CountW  = AddrW + 1;
  localparam int unsigned ProdW   = 32 + TwBits + 1;
  localparam int unsigned TwShift = 61 - TwBits;
  localparam logic [63:0] PiQ60   = 64'h3243F6A8885A308D;
  localparam logic signed [63:0] TwOne = (64'sd1 <<< (TwBits - 1)) - 64'sd1;

  typedef enum logic {
    OpPush = 1'b0,
    OpPull = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdA,
    StRdB,
    StMul,
    StAdd,
    StWr
  } state_e;

  typedef struct packed {
    logic             load_wr;
    logic [AddrW-1:0] load_addr;
    logic             rd_a;
    logic             rd_b;
    logic             mul;
    logic             add;
    logic             wr_a;
    logic             wr_b;
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
    logic [AddrW-1:0] tw_exp;
    logic             pull_rd;
    logic [AddrW-1:0] pull_addr;
  } cmd_t;

  typedef struct packed {
    logic rd_valid;
  } stat_t;

  typedef logic [Quarter:0][TwBits-1:0] cos_table_t;

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r    = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave cosine in Q1.15, computed at elaboration in Q60 fixed point.
  function automatic cos_table_t build_cos_table();
    cos_table_t         tab;
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    tab = '0;
    for (int unsigned k = 0; k <= Quarter; k++) begin
      th  = mul_shr(PiQ60, 64'(k), AddrW - 1);
      x2  = mul_shr(th, th, 60);
      t   = 64'd1 << 60;
      sum = $signed(t);
      for (int unsigned n = 1; n <= 13; n++) begin
        t = div_u64(mul_shr(t, x2, 60), 64'((2 * n - 1) * (2 * n)));
        if ((n & 1) == 1) sum = sum - $signed(t);
        else sum = sum + $signed(t);
      end
      if (sum < 0) sum = '0;
      r = (sum + (64'sd1 <<< (TwShift - 1))) >>> TwShift;
      if (r > TwOne) r = TwOne;
      tab[k] = r[TwBits-1:0];
    end
    return tab;
  endfunction

  localparam cos_table_t CosTable = build_cos_table();

endpackage

/* sv/fft_ctrl.sv */
// ----------------------------------------------------------------------------
// FFT controller
// Sequences load, butterfly passes and readout over the work memory.
// ----------------------------------------------------------------------------
module fft_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic                         out_ready_o,
  output logic                         out_last_o,
  output logic [fft_pkg::AddrW-1:0]    out_index_o,
  output fft_pkg::cmd_t                cmd_o,
  input  fft_pkg::stat_t               stat_i
);

  fft_pkg::state_e state_q, state_d;
  logic [fft_pkg::CountW-1:0] load_q, load_d;
  logic [fft_pkg::CountW-1:0] read_q, read_d;
  logic done_q, done_d;
  logic [fft_pkg::PassW-1:0] pass_q, pass_d;
  logic [fft_pkg::AddrW-2:0] bfly_q, bfly_d;
  logic pend_q, pend_d;
  logic pready_q, pready_d;
  logic plast_q, plast_d;
  logic [fft_pkg::AddrW-1:0] pidx_q, pidx_d;
  logic ovalid_q, ovalid_d;
  logic accept, push, pull;
  logic [fft_pkg::AddrW-1:0] lo_mask, j, ia, ib, brev;
  logic last_bfly;

  assign in_stall_o  = (state_q != fft_pkg::StIdle) || pend_q || (ovalid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign push        = accept && (opcode_i == fft_pkg::OpPush);
  assign pull        = accept && (opcode_i == fft_pkg::OpPull);
  assign out_valid_o = ovalid_q;
  assign out_ready_o = pready_q;
  assign out_last_o  = plast_q;
  assign out_index_o = pidx_q;

  always_comb begin
    for (int b = 0; b < fft_pkg::AddrW; b++) begin
      brev[b]    = load_q[fft_pkg::AddrW-1-b];
      lo_mask[b] = (b < int'(pass_q));
    end
    j  = {1'b0, bfly_q} & lo_mask;
    ia = (({bfly_q, 1'b0} & ~((lo_mask << 1) | fft_pkg::AddrW'(1))) | j);
    ib = ia | (fft_pkg::AddrW'(1) << pass_q);
  end

  assign last_bfly = (bfly_q == '1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fft_pkg::StIdle: if (push && !done_q && load_q == fft_pkg::CountW'(fft_pkg::Points - 1))
        state_d = fft_pkg::StRdA;
      fft_pkg::StRdA: state_d = fft_pkg::StRdB;
      fft_pkg::StRdB: state_d = fft_pkg::StMul;
      fft_pkg::StMul: state_d = fft_pkg::StAdd;
      fft_pkg::StAdd: state_d = fft_pkg::StWr;
      fft_pkg::StWr: begin
        if (last_bfly && pass_q == fft_pkg::PassW'(fft_pkg::Passes - 1)) state_d = fft_pkg::StIdle;
        else state_d = fft_pkg::StRdA;
      end
      default: state_d = fft_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load_wr   = push && !done_q;
    cmd_o.load_addr = brev;
    cmd_o.addr_a    = ia;
    cmd_o.addr_b    = ib;
    cmd_o.tw_exp    = fft_pkg::AddrW'(j << (fft_pkg::AddrW - 1 - int'(pass_q)));
    cmd_o.pull_addr = read_q[fft_pkg::AddrW-1:0];
    cmd_o.pull_rd   = pull && done_q;
    unique case (state_q)
      fft_pkg::StRdA: cmd_o.rd_a = 1'b1;
      fft_pkg::StRdB: cmd_o.rd_b = 1'b1;
      fft_pkg::StMul: cmd_o.mul  = 1'b1;
      fft_pkg::StAdd: begin
        cmd_o.add  = 1'b1;
        cmd_o.wr_b = 1'b1;
      end
      fft_pkg::StWr: cmd_o.wr_a = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    load_d   = load_q;
    read_d   = read_q;
    done_d   = done_q;
    pass_d   = pass_q;
    bfly_d   = bfly_q;
    pend_d   = 1'b0;
    pready_d = pready_q;
    plast_d  = plast_q;
    pidx_d   = pidx_q;
    ovalid_d = ovalid_q && out_stall_i;
    if (push && !done_q) load_d = load_q + 1'b1;
    if (state_q == fft_pkg::StWr) begin
      bfly_d = bfly_q + 1'b1;
      if (last_bfly) begin
        if (pass_q == fft_pkg::PassW'(fft_pkg::Passes - 1)) begin
          pass_d = '0;
          done_d = 1'b1;
          read_d = '0;
        end else begin
          pass_d = pass_q + 1'b1;
        end
      end
    end
    if (pull) begin
      if (done_q) begin
        pend_d   = 1'b1;
        pready_d = 1'b1;
        pidx_d   = read_q[fft_pkg::AddrW-1:0];
        plast_d  = (read_q == fft_pkg::CountW'(fft_pkg::Points - 1));
        read_d   = read_q + 1'b1;
        if (read_q == fft_pkg::CountW'(fft_pkg::Points - 1)) begin
          done_d = 1'b0;
          load_d = '0;
          read_d = '0;
        end
      end else begin
        ovalid_d = 1'b1;
        pready_d = 1'b0;
        plast_d  = 1'b0;
        pidx_d   = '0;
      end
    end
    if (pend_q && stat_i.rd_valid) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fft_pkg::StIdle;
      load_q   <= '0;
      read_q   <= '0;
      done_q   <= 1'b0;
      pass_q   <= '0;
      bfly_q   <= '0;
      pend_q   <= 1'b0;
      pready_q <= 1'b0;
      plast_q  <= 1'b0;
      pidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      load_q   <= load_d;
      read_q   <= read_d;
      done_q   <= done_d;
      pass_q   <= pass_d;
      bfly_q   <= bfly_d;
      pend_q   <= pend_d;
      pready_q <= pready_d;
      plast_q  <= plast_d;
      pidx_q   <= pidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fft_pkg::StIdle) |-> !accept) else $error("accept during transform");
  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> ovalid_q) else $error("pull beat lost");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == fft_pkg::StIdle)) else $error("done while busy");

endmodule

/* sv/fft_dp.sv */
// ----------------------------------------------------------------------------
// FFT datapath
// Work memory, twiddle lookup, complex multiply and saturating butterfly.
// ----------------------------------------------------------------------------
module fft_dp (
  input  logic                clk_i,
  input  logic                inverse_i,
  input  logic signed [15:0]  sample_real_i,
  input  logic signed [15:0]  sample_imag_i,
  input  fft_pkg::cmd_t       cmd_i,
  output fft_pkg::stat_t      stat_o,
  output logic signed [31:0]  rd_real_o,
  output logic signed [31:0]  rd_imag_o
);

  localparam int unsigned Tw = fft_pkg::TwBits;

  logic [63:0] mem [fft_pkg::Points];
  logic [63:0] rd_q;
  logic        rdv_q;
  logic signed [31:0] ar_q, ai_q;
  logic signed [Tw-1:0] c_q, s_q, c_d, s_d;
  logic signed [fft_pkg::ProdW:0] pcr_q, psi_q, pci_q, psr_q;
  logic signed [fft_pkg::ProdW+1:0] tr, ti;
  logic signed [33:0] sa_r, sa_i, sb_r, sb_i;
  logic [63:0] na_q;
  logic [fft_pkg::AddrW-1:0] e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [Tw-1:0] rom(input logic [fft_pkg::QAddrW-1:0] k);
    return fft_pkg::CosTable[k];
  endfunction

  assign e = cmd_i.tw_exp;

  always_comb begin
    if (e == '0) begin
      c_d = Tw'((1 << (Tw - 1)) - 1);
      s_d = '0;
    end else if (e <= fft_pkg::AddrW'(fft_pkg::Quarter)) begin
      c_d = rom(fft_pkg::QAddrW'(e));
      s_d = rom(fft_pkg::QAddrW'(fft_pkg::AddrW'(fft_pkg::Quarter) - e));
    end else begin
      c_d = -rom(fft_pkg::QAddrW'(fft_pkg::AddrW'(fft_pkg::Points / 2) - e));
      s_d = rom(fft_pkg::QAddrW'(e - fft_pkg::AddrW'(fft_pkg::Quarter)));
    end
    if (inverse_i) s_d = -s_d;
  end

  assign tr = (pcr_q - psi_q + (1 <<< (Tw - 2))) >>> (Tw - 1);
  assign ti = (pci_q + psr_q + (1 <<< (Tw - 2))) >>> (Tw - 1);
  assign sa_r = 34'(ar_q) + 34'(tr);
  assign sa_i = 34'(ai_q) + 34'(ti);
  assign sb_r = 34'(ar_q) - 34'(tr);
  assign sb_i = 34'(ai_q) - 34'(ti);

  always_ff @(posedge clk_i) begin
    rdv_q <= cmd_i.pull_rd;
    if (cmd_i.load_wr)
      mem[cmd_i.load_addr] <= {32'(sample_real_i), 32'(sample_imag_i)};
    else if (cmd_i.wr_a)
      mem[cmd_i.addr_a] <= na_q;
    else if (cmd_i.wr_b)
      mem[cmd_i.addr_b] <= {sat32(sb_r), sat32(sb_i)};
    if (cmd_i.rd_a || cmd_i.pull_rd)
      rd_q <= mem[cmd_i.pull_rd ? cmd_i.pull_addr : cmd_i.addr_a];
    else if (cmd_i.rd_b)
      rd_q <= mem[cmd_i.addr_b];
    if (cmd_i.rd_b) begin
      ar_q <= rd_q[63:32];
      ai_q <= rd_q[31:0];
      c_q  <= c_d;
      s_q  <= s_d;
    end
    if (cmd_i.mul) begin
      pcr_q <= c_q * $signed(rd_q[63:32]);
      psi_q <= s_q * $signed(rd_q[31:0]);
      pci_q <= c_q * $signed(rd_q[31:0]);
      psr_q <= s_q * $signed(rd_q[63:32]);
    end
    if (cmd_i.add) begin
      na_q <= {sat32(sa_r), sat32(sa_i)};
    end
  end

  assign stat_o.rd_valid = rdv_q;
  assign rd_real_o = rd_q[63:32];
  assign rd_imag_o = rd_q[31:0];

endmodule

/* sv/radix2_fft_in_place.sv */
// ----------------------------------------------------------------------------
// Radix-2 in-place FFT
// 1024-point complex DIT FFT with push/pull item channel and saturated bins.
// ----------------------------------------------------------------------------
// Usage: each input beat carries an opcode. A push beat writes one sample in
// natural order; the 1024th push starts 10 butterfly passes over the work
// memory. Each butterfly does read A, read B, multiply, add with write B and
// write A on the single memory port; the input stalls during the transform.
// A pull beat returns one bin via the memory read and bin holding registers;
// before the transform is done it returns in the next cycle with ready cleared.
// Pushes made while a frame waits to be read are dropped. The pull of the last
// bin rearms loading. The single-port work memory sets the butterfly rate.
// When the receiver stalls, the result is held and the input stalls. Reset
// clears counters and flags; the memory is not cleared. The user must write
// inverse_mode on the config channel only while idle; the block has no check.
// ----------------------------------------------------------------------------
module radix2_fft_in_place (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_inverse_mode_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [15:0] sample_real_i,
  input  logic signed [15:0] sample_imag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] bin_real_o,
  output logic signed [31:0] bin_imag_o,
  output logic [9:0]         bin_index_o,
  output logic               last_bin_o,
  output logic               ready_res_o
);

  logic inv_q;
  fft_pkg::cmd_t  cmd;
  fft_pkg::stat_t stat;
  logic signed [31:0] rr, ri;
  logic rdy;
  logic [fft_pkg::AddrW-1:0] idx;
  logic signed [31:0] hr_q, hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inv_q <= 1'b0;
    else if (cfg_valid_i) inv_q <= cfg_inverse_mode_i;
  end

  fft_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .out_stall_i,
    .out_valid_o, .out_ready_o(rdy), .out_last_o(last_bin_o), .out_index_o(idx),
    .cmd_o(cmd), .stat_i(stat)
  );

  fft_dp u_dp (
    .clk_i, .inverse_i(inv_q), .sample_real_i, .sample_imag_i, .cmd_i(cmd),
    .stat_o(stat), .rd_real_o(rr), .rd_imag_o(ri)
  );

  always_ff @(posedge clk_i) begin
    if (stat.rd_valid) begin
      hr_q <= rr;
      hi_q <= ri;
    end
  end

  assign ready_res_o = rdy;
  assign bin_real_o  = rdy ? hr_q : 32'sd0;
  assign bin_imag_o  = rdy ? hi_q : 32'sd0;
  assign bin_index_o = 10'(idx);

endmodule
